>>> hw/rtl/ilpd_pkg.sv
package ilpd_pkg;

    localparam int unsigned RUN_W   = 16;
    localparam int unsigned PULSE_W = 8;
    localparam int unsigned FLAT_W  = 12;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned CFG_IDX_W = 3;

    // Phase codes
    localparam logic [PHASE_W-1:0] PH_NOCONN = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CONN   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_DIG1   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DIG2   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_ENDED  = 3'd5;

    // Link status codes
    localparam logic [1:0] LINK_DOWN = 2'd0;
    localparam logic [1:0] LINK_UP   = 2'd1;
    localparam logic [1:0] LINK_RX   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DISCONNECT_LOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CALL_START_LOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_END_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_HIGH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CALL_END_LOW   = 3'd4;

    // Reset values of the thresholds
    localparam logic [RUN_W-1:0] RST_DISCONNECT_LOW = 16'd1000;
    localparam logic [RUN_W-1:0] RST_CALL_START_LOW = 16'd100;
    localparam logic [RUN_W-1:0] RST_DIGIT_END_HIGH = 16'd50;
    localparam logic [RUN_W-1:0] RST_IDLE_HIGH      = 16'd200;
    localparam logic [RUN_W-1:0] RST_CALL_END_LOW   = 16'd300;

    // Digit arithmetic
    localparam logic [PULSE_W-1:0]  PULSE_TEN_ALIAS = 8'd11;
    localparam logic [FLAT_W:0]     FLAT_FOLD_LO    = 13'd100;
    localparam logic [FLAT_W:0]     FLAT_FOLD_HI    = 13'd110;
    localparam logic [FLAT_W:0]     FLAT_FOLD_SUB   = 13'd100;

    typedef struct packed {
        logic [RUN_W-1:0] disconnect_low_run;
        logic [RUN_W-1:0] call_start_low_run;
        logic [RUN_W-1:0] digit_end_high_run;
        logic [RUN_W-1:0] idle_high_run;
        logic [RUN_W-1:0] call_end_low_run;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        link_status;
        logic              led_on;
        logic              flat_valid;
        logic [FLAT_W-1:0] flat_number;
    } result_t;

endpackage

>>> hw/rtl/ilpd_cfg_regs.sv
module ilpd_cfg_regs
    import ilpd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RUN_W-1:0]     cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.disconnect_low_run <= RST_DISCONNECT_LOW;
            cfg_reg.call_start_low_run <= RST_CALL_START_LOW;
            cfg_reg.digit_end_high_run <= RST_DIGIT_END_HIGH;
            cfg_reg.idle_high_run      <= RST_IDLE_HIGH;
            cfg_reg.call_end_low_run   <= RST_CALL_END_LOW;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DISCONNECT_LOW: cfg_reg.disconnect_low_run <= cfg_wdata;
                CFG_CALL_START_LOW: cfg_reg.call_start_low_run <= cfg_wdata;
                CFG_DIGIT_END_HIGH: cfg_reg.digit_end_high_run <= cfg_wdata;
                CFG_IDLE_HIGH:      cfg_reg.idle_high_run      <= cfg_wdata;
                CFG_CALL_END_LOW:   cfg_reg.call_end_low_run   <= cfg_wdata;
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/ilpd_core.sv
module ilpd_core
    import ilpd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step_en,
    input  logic    line_level,
    input  cfg_t    cfg,
    output result_t result
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [RUN_W-1:0]   low_run_reg, low_run_next;
    logic [RUN_W-1:0]   high_run_reg, high_run_next;
    logic               last_level_reg, last_level_next;
    logic [PULSE_W-1:0] pulse_count_reg, pulse_count_next;
    logic [FLAT_W-1:0]  flat_reg, flat_next;
    logic [1:0]         status_reg, status_next;
    logic               lamp_reg, lamp_next;

    logic [RUN_W-1:0]   low_inc, high_inc;
    logic [PULSE_W-1:0] pulse_upd, digit_val;
    logic [FLAT_W:0]    flat_sum;
    logic               closed, idle_hit, go_en, valid;
    logic [PHASE_W-1:0] go_phase;

    assign low_inc  = (low_run_reg == '1) ? low_run_reg : low_run_reg + 1'b1;
    assign high_inc = (high_run_reg == '1) ? high_run_reg : high_run_reg + 1'b1;

    // Count a pulse on every high-to-low edge during the digit phases, saturating at all ones
    assign pulse_upd = (last_level_reg && !line_level && pulse_count_reg != '1)
                       ? pulse_count_reg + 1'b1 : pulse_count_reg;
    assign digit_val = (pulse_upd == PULSE_TEN_ALIAS) ? PULSE_W'(1) : pulse_upd;
    assign flat_sum  = {1'b0, flat_reg} + {{(FLAT_W+1-PULSE_W){1'b0}}, digit_val}
                       - (FLAT_W+1)'(1);

    assign closed   = line_level && (high_inc >= cfg.digit_end_high_run);
    // After a digit closes the high run is cleared, so only a zero threshold hits
    assign idle_hit = line_level && (closed ? (cfg.idle_high_run == '0)
                                            : (high_inc >= cfg.idle_high_run));

    always_comb begin
        low_run_next     = low_run_reg;
        high_run_next    = high_run_reg;
        last_level_next  = last_level_reg;
        pulse_count_next = pulse_count_reg;
        flat_next        = flat_reg;
        go_en            = 1'b0;
        go_phase         = phase_reg;
        valid            = 1'b0;

        unique case (phase_reg) inside
            PH_CONN: begin
                if (!line_level) begin
                    low_run_next = low_inc;
                    if (low_inc >= cfg.disconnect_low_run) begin
                        go_en    = 1'b1;
                        go_phase = PH_NOCONN;
                    end
                end else if (low_run_reg >= cfg.call_start_low_run) begin
                    go_en    = 1'b1;
                    go_phase = PH_DIG1;
                end
            end
            PH_DIG1, PH_DIG2: begin
                pulse_count_next = pulse_upd;
                last_level_next  = line_level;
                if (!line_level) begin
                    high_run_next = '0;
                    low_run_next  = low_inc;
                end else begin
                    low_run_next  = '0;
                    high_run_next = high_inc;
                end
                if (closed) begin
                    if (phase_reg == PH_DIG1) begin
                        flat_next = FLAT_W'({pulse_upd, 3'b000})
                                  + FLAT_W'({pulse_upd, 1'b0});
                    end else begin
                        flat_next = (flat_sum > FLAT_FOLD_LO && flat_sum < FLAT_FOLD_HI)
                                  ? FLAT_W'(flat_sum - FLAT_FOLD_SUB)
                                  : flat_sum[FLAT_W-1:0];
                        valid     = 1'b1;
                    end
                    go_en    = 1'b1;
                    go_phase = (phase_reg == PH_DIG1) ? PH_DIG2 : PH_DATA;
                end
                if (idle_hit) begin
                    go_en    = 1'b1;
                    go_phase = PH_CONN;
                end
            end
            PH_DATA, PH_ENDED: begin
                if (!line_level) begin
                    low_run_next = low_inc;
                    if (phase_reg == PH_DATA && low_inc >= cfg.call_end_low_run) begin
                        go_en    = 1'b1;
                        go_phase = PH_ENDED;
                    end else if (phase_reg == PH_ENDED
                                 && low_inc >= cfg.disconnect_low_run) begin
                        go_en    = 1'b1;
                        go_phase = PH_NOCONN;
                    end
                end else begin
                    high_run_next = high_inc;
                    if (high_inc >= cfg.idle_high_run) begin
                        go_en    = 1'b1;
                        go_phase = PH_CONN;
                    end
                end
            end
            default: begin
                if (line_level) begin
                    go_en    = 1'b1;
                    go_phase = PH_CONN;
                end
            end
        endcase

        phase_next  = phase_reg;
        status_next = status_reg;
        lamp_next   = lamp_reg;
        if (go_en) begin
            phase_next       = go_phase;
            low_run_next     = '0;
            high_run_next    = '0;
            last_level_next  = 1'b0;
            pulse_count_next = PULSE_W'(1);
            if (go_phase == PH_NOCONN) begin
                status_next = LINK_DOWN;
                lamp_next   = 1'b0;
            end else if (go_phase == PH_CONN) begin
                status_next = LINK_UP;
                lamp_next   = 1'b1;
            end else if (go_phase == PH_DIG1) begin
                status_next = LINK_RX;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_CONN;
            low_run_reg     <= '0;
            high_run_reg    <= '0;
            last_level_reg  <= 1'b0;
            pulse_count_reg <= PULSE_W'(1);
            flat_reg        <= '0;
            status_reg      <= LINK_UP;
            lamp_reg        <= 1'b1;
        end else if (step_en) begin
            phase_reg       <= phase_next;
            low_run_reg     <= low_run_next;
            high_run_reg    <= high_run_next;
            last_level_reg  <= last_level_next;
            pulse_count_reg <= pulse_count_next;
            flat_reg        <= flat_next;
            status_reg      <= status_next;
            lamp_reg        <= lamp_next;
        end
    end

    assign result.link_status = status_next;
    assign result.led_on      = lamp_next;
    assign result.flat_valid  = valid;
    assign result.flat_number = flat_next;

endmodule

>>> hw/rtl/ilpd_out_skid.sv
module ilpd_out_skid
    import ilpd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg, skid_valid_reg;
    result_t main_reg, skid_reg;

    assign in_ready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || out_ready) begin
            // Output slot frees up: refill from skid first, else from input
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= in_valid;
            end
        end else if (in_valid && in_ready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!main_valid_reg || out_ready) begin
            main_reg <= skid_valid_reg ? skid_reg : in_data;
        end else if (in_valid && in_ready) begin
            skid_reg <= in_data;
        end
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

>>> hw/rtl/intercom_line_pulse_decoder.sv
// Intercom line pulse decoder.
// Input stream: one sampled line level per transfer in s_tdata[0]. Output
// stream: one result transfer per input transfer, carrying link status, the
// indicator lamp and the last flat number; m_tuser marks the transfer on which
// a new flat number completes. Thresholds are set through the cfg_* write
// port (index 0..4); write them only while the block is idle.
// A result is registered in the output buffer before it shows on m_tvalid.
// Throughput: one transfer per cycle while m_tready is high; the phase update
// is a single pass of logic from the state registers into the output register.
// Reset (aresetn low, synchronous): the phase returns to connected, run
// counters clear, thresholds reload their defaults and the output stream empties.
// Stall: while m_tready is low the output holds its result; a two-entry
// output buffer takes one more input, then s_tready drops until the
// receiver resumes. No result is dropped or repeated.
module intercom_line_pulse_decoder
    import ilpd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // line_level [0], zero padding [7:1]
    input  logic [7:0]           s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // link_status [1:0], led_on [2], flat_number [14:3], zero padding [15]
    output logic [15:0]          m_tdata,
    // flat_valid [0]
    output logic                 m_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RUN_W-1:0]     cfg_wdata
);

    cfg_t    cfg;
    result_t core_result, out_result;
    logic    step_en;

    ilpd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Advance the decoder state on every accepted input transfer
    assign step_en = s_tvalid && s_tready;

    ilpd_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step_en),
        .line_level (s_tdata[0]),
        .cfg        (cfg),
        .result     (core_result)
    );

    ilpd_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (core_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    // Pack the result fields, lowest bit first
    assign m_tdata = {1'b0, out_result.flat_number, out_result.led_on,
                      out_result.link_status};
    assign m_tuser = out_result.flat_valid;

endmodule

>>> hw/rtl/ilpd_checker.sv
module ilpd_checker
    import ilpd_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tvalid,
    input logic        m_tready
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_link_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("undefined link status");

    // Lamp is off exactly when the link is down
    a_lamp_link: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2] == (m_tdata[1:0] != LINK_DOWN)))
        else $error("lamp disagrees with link status");

    // A flat number completes only while receiving or just back to idle
    a_flat_link: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[1:0] == LINK_RX || m_tdata[1:0] == LINK_UP))
        else $error("flat number completed with link down");

endmodule

bind intercom_line_pulse_decoder ilpd_checker u_ilpd_checker (.*);
